// File: src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, types and helpers of the bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package bba_pkg;
	localparam int BLOCKS_PER_GROUP_DEF = 1024;
	localparam int BITMAP_BYTES_DEF     = 128;
	localparam int MAX_GROUPS_DEF       = 16;
	localparam int BLK_W                = 14;

	typedef enum logic [0:0] {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	typedef enum logic [3:0] {
		ST_CLEAR,    // sweep after reset: every byte to its reset value
		ST_IDLE,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_HINT_RD,
		ST_HINT_CHK,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_NEW_CLR,  // clear a newly activated group
		ST_DONE
	} state_t;

	// lowest zero bit of a byte, 7 when only bit 7 is clear or byte is full
	function automatic logic [2:0] lowest_zero(input logic [7:0] b);
		logic [2:0] k;
		k = 3'd7;
		for (int i = 6; i >= 0; i--)
			if (!b[i]) k = 3'(i);
		return k;
	endfunction
endpackage
`default_nettype wire

// File: src/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// File: src/bitmap_block_allocator_with_hint.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_with_hint
// Bitmap block allocator with locality hint, one bitmap byte tested per step.
// ----------------------------------------------------------------------------
// Each request word (func, block_no) yields one result word (result_block,
// ok). The bitmap lives in one single-port RAM of MAX_GROUPS*BITMAP_BYTES
// bytes; a small sequencer reads one byte at a time, in a read state and
// then a test state, and one byte test/compare unit does all passes. An
// allocate first tests the hint's byte; if that byte is full it runs the
// fully-free and any-free passes over the hint group, then a byte-0 check
// and the same two passes per other active group, and a clearing sweep of
// BITMAP_BYTES bytes when a new group is activated. After reset a clearing
// pass over all MAX_GROUPS*BITMAP_BYTES bytes runs before the first request
// is taken. The result sits in an output register; the next request is
// taken after it is delivered.
`default_nettype none
module bitmap_block_allocator_with_hint #(
	parameter int BLOCKS_PER_GROUP = bba_pkg::BLOCKS_PER_GROUP_DEF,
	parameter int BITMAP_BYTES     = bba_pkg::BITMAP_BYTES_DEF,
	parameter int MAX_GROUPS       = bba_pkg::MAX_GROUPS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [0] func, [14:1] block_no, [15] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata    // [13:0] result_block, [14] ok, [15] zero
);
	localparam int BLK_W   = bba_pkg::BLK_W;
	localparam int USABLE  = (BITMAP_BYTES < BLOCKS_PER_GROUP / 8) ?
	                         BITMAP_BYTES : BLOCKS_PER_GROUP / 8;
	localparam int DEPTH   = MAX_GROUPS * BITMAP_BYTES;
	localparam int AW      = $clog2(DEPTH);
	localparam int BW      = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
	localparam int GW      = $clog2(MAX_GROUPS + 1);
	localparam int GIW     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int PW      = $clog2(BLOCKS_PER_GROUP);
	localparam int CW      = $clog2(USABLE + 1);

	bba_pkg::state_t state_q, state_d;

	logic [GW-1:0]    groups_q;      // active group count
	logic [GIW-1:0]   grp_q;         // group under search
	logic [BW-1:0]    byte_q;        // byte under search
	logic [BW-1:0]    start_q;
	logic [CW-1:0]    cnt_q;         // bytes visited in this pass
	logic [1:0]       pass_q;        // 0 fully free, 1 any free
	logic [GW-1:0]    gcnt_q;        // other groups tried
	logic [AW-1:0]    clr_q;
	logic [PW-1:0]    pos_q;
	logic             func_q;
	logic [BLK_W-1:0] res_q;
	logic             ok_q;
	logic             out_v_q;

	// request decode
	logic [BLK_W-1:0] in_blk;
	logic [BLK_W-1:0] in_grp;
	logic [PW-1:0]    in_pos;
	assign in_blk = s_tdata[BLK_W:1];
	assign in_grp = BLK_W'(in_blk / BLOCKS_PER_GROUP);
	assign in_pos = PW'(in_blk % BLOCKS_PER_GROUP);

	// RAM port
	logic          we;
	logic [AW-1:0] addr;
	logic [7:0]    wdata, rdata;

	bba_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	function automatic logic [AW-1:0] mkaddr(input logic [GIW-1:0] g, input logic [BW-1:0] b);
		return AW'(g) * AW'(BITMAP_BYTES) + AW'(b);
	endfunction

	// shared byte test unit
	logic [2:0] lz;
	logic       full, empty;
	assign lz    = bba_pkg::lowest_zero(rdata);
	assign full  = (rdata == 8'hff);
	assign empty = (rdata == 8'h00);

	logic [BW-1:0] byte_nx;
	assign byte_nx = (32'(byte_q) + 1 >= USABLE) ? '0 : BW'(32'(byte_q) + 1);

	logic [GIW-1:0] grp_nx;
	assign grp_nx = (GW'(grp_q) + 1'b1 >= groups_q) ? '0 : GIW'(GW'(grp_q) + 1'b1);

	logic [BLK_W-1:0] hit_blk;
	assign hit_blk = BLK_W'(32'(grp_q) * BLOCKS_PER_GROUP + 32'(byte_q) * 8 + 32'(lz));

	logic free_ok;
	assign free_ok = (GW'(in_grp) < groups_q) && (in_grp < BLK_W'(MAX_GROUPS))
	                 && (in_pos >= PW'(2)) && (32'(in_pos) / 8 < USABLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bba_pkg::ST_CLEAR;
			groups_q <= GW'(1);
			clr_q    <= '0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (m_tvalid && m_tready) out_v_q <= 1'b0;
			unique case (state_q)
				bba_pkg::ST_CLEAR, bba_pkg::ST_NEW_CLR: clr_q <= clr_q + 1'b1;
				bba_pkg::ST_IDLE: if (s_tvalid && s_tready) begin
					func_q <= s_tdata[0];
					pos_q  <= in_pos;
					res_q  <= '0;
					ok_q   <= 1'b0;
					if (s_tdata[0] == bba_pkg::FUNC_FREE) begin
						grp_q  <= GIW'(in_grp);
						byte_q <= BW'(in_pos >> 3);
						ok_q   <= free_ok;
					end else if (GW'(in_grp) < groups_q && in_grp < BLK_W'(MAX_GROUPS)) begin
						grp_q   <= GIW'(in_grp);
						byte_q  <= BW'((32'(in_pos) / 8) % USABLE);
						start_q <= BW'((32'(in_pos) / 8) % USABLE);
					end else begin
						grp_q   <= '0;
						byte_q  <= '0;
						start_q <= '0;
					end
					cnt_q  <= '0;
					pass_q <= 2'd0;
					gcnt_q <= '0;
				end
				bba_pkg::ST_HINT_CHK: if (!full) begin
					res_q <= hit_blk; ok_q <= 1'b1;
				end
				bba_pkg::ST_SCAN_CHK: begin
					if ((pass_q == 2'd0 && empty) || (pass_q != 2'd0 && !full)) begin
						res_q <= (pass_q == 2'd0) ? BLK_W'(32'(grp_q) * BLOCKS_PER_GROUP
						         + 32'(byte_q) * 8) : hit_blk;
						ok_q  <= 1'b1;
					end else if (32'(cnt_q) + 1 < USABLE) begin
						cnt_q  <= cnt_q + 1'b1;
						byte_q <= byte_nx;
					end else begin
						cnt_q <= '0;
						if (pass_q == 2'd0) begin
							pass_q <= 2'd1; byte_q <= start_q;
						end else if (GW'(32'(gcnt_q) + 1) < groups_q) begin
							// next group: byte 0 first, then both passes from byte 0
							gcnt_q <= gcnt_q + 1'b1; grp_q <= grp_nx; byte_q <= '0;
							pass_q <= 2'd0; start_q <= '0;
						end else if (groups_q < GW'(MAX_GROUPS)) begin
							grp_q    <= GIW'(groups_q);
							groups_q <= groups_q + 1'b1;
							clr_q    <= mkaddr(GIW'(groups_q), '0);
							byte_q   <= '0;
						end
					end
				end
				bba_pkg::ST_DONE: out_v_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		addr    = mkaddr(grp_q, byte_q);
		wdata   = rdata | (8'h01 << lz);
		unique case (state_q)
			bba_pkg::ST_CLEAR: begin
				we = 1'b1; addr = clr_q;
				wdata = (32'(clr_q) % BITMAP_BYTES == 0) ? 8'h03 : 8'h00;
				if (32'(clr_q) == DEPTH - 1) state_d = bba_pkg::ST_IDLE;
			end
			bba_pkg::ST_NEW_CLR: begin
				we = 1'b1; addr = clr_q;
				wdata = (32'(clr_q) % BITMAP_BYTES == 0) ? 8'h03 : 8'h00;
				if (32'(clr_q) % BITMAP_BYTES == BITMAP_BYTES - 1)
					state_d = bba_pkg::ST_SCAN_RD;
			end
			bba_pkg::ST_IDLE: if (s_tvalid && s_tready)
				state_d = (s_tdata[0] == bba_pkg::FUNC_FREE) ?
				          bba_pkg::ST_FREE_RD : bba_pkg::ST_HINT_RD;
			bba_pkg::ST_FREE_RD: state_d = ok_q ? bba_pkg::ST_FREE_WR : bba_pkg::ST_DONE;
			bba_pkg::ST_FREE_WR: begin
				we = 1'b1; wdata = rdata & ~(8'h01 << pos_q[2:0]);
				state_d = bba_pkg::ST_DONE;
			end
			bba_pkg::ST_HINT_RD: state_d = bba_pkg::ST_HINT_CHK;
			bba_pkg::ST_HINT_CHK: begin
				if (!full) begin
					we = 1'b1; state_d = bba_pkg::ST_DONE;
				end else state_d = bba_pkg::ST_SCAN_RD;
			end
			bba_pkg::ST_SCAN_RD: state_d = bba_pkg::ST_SCAN_CHK;
			bba_pkg::ST_SCAN_CHK: begin
				if ((pass_q == 2'd0 && empty) || (pass_q != 2'd0 && !full)) begin
					we = 1'b1;
					if (pass_q == 2'd0) wdata = 8'h01;
					state_d = bba_pkg::ST_DONE;
				end else if (32'(cnt_q) + 1 < USABLE) state_d = bba_pkg::ST_SCAN_RD;
				else if (pass_q == 2'd0) state_d = bba_pkg::ST_SCAN_RD;
				else if (GW'(32'(gcnt_q) + 1) < groups_q) state_d = bba_pkg::ST_HINT_RD;
				else if (groups_q < GW'(MAX_GROUPS)) state_d = bba_pkg::ST_NEW_CLR;
				else state_d = bba_pkg::ST_DONE;
			end
			bba_pkg::ST_DONE: state_d = bba_pkg::ST_IDLE;
			default: state_d = bba_pkg::ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == bba_pkg::ST_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {1'b0, ok_q, res_q};

	logic unused;
	assign unused = func_q ^ s_tdata[15];
endmodule
`default_nettype wire

// File: src/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module bba_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);
	// no new request while a result waits
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("request taken with result pending");
	// a failed word carries block zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[14] |-> m_tdata[13:0] == 14'd0) else $error("fail nonzero");
	// pending result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	// acceptance closes the ready window
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("ready after accept");
endmodule

bind bitmap_block_allocator_with_hint bba_checker u_chk (.*);
`default_nettype wire
